// ----- rtl/vsb_pkg.sv -----
// Shared types, widths, register codes and reset values for the Verlet step block.
package vsb_pkg;

  localparam int POS_W      = 24;
  localparam int RAD_W      = 16;
  localparam int MV_W       = POS_W + 1;
  localparam int DAMP_W     = 8;
  localparam int DMV_W      = MV_W + DAMP_W;
  localparam int DT_W       = 16;
  localparam int ACC_W      = 16;
  localparam int EXT_W      = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [POS_W-1:0] POS_MAX_C = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN_C = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [DT_W-1:0]   STEP_TIME_RST   = 16'd1092;
  localparam logic [ACC_W-1:0]  ACCEL_X_RST     = 16'd0;
  localparam logic [ACC_W-1:0]  GRAVITY_Y_RST   = 16'd200;
  localparam logic [DAMP_W-1:0] DAMPING_RST     = 8'd40;
  localparam logic [EXT_W-1:0]  AREA_WIDTH_RST  = 15'd800;
  localparam logic [EXT_W-1:0]  AREA_HEIGHT_RST = 15'd450;
  localparam logic [DT_W-1:0]   DT2_RST =
    16'((32'(STEP_TIME_RST) * 32'(STEP_TIME_RST)) >> 16);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP_TIME   = 3'd0,
    CFG_ACCEL_X     = 3'd1,
    CFG_GRAVITY_Y   = 3'd2,
    CFG_DAMPING     = 3'd3,
    CFG_AREA_WIDTH  = 3'd4,
    CFG_AREA_HEIGHT = 3'd5
  } cfg_idx_t;

  // One particle after the front stage: position, motion and drag term per axis.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [MV_W-1:0]  mv_x;
    logic signed [MV_W-1:0]  mv_y;
    logic signed [DMV_W-1:0] dmv_x;
    logic signed [DMV_W-1:0] dmv_y;
    logic        [RAD_W-1:0] radius;
  } front_item_t;

endpackage

// ----- rtl/vsb_front.sv -----
// Front stage: takes a particle beat, forms the motion per axis and its drag product.
module vsb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [vsb_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vsb_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vsb_pkg::POS_W-1:0]   prev_x,
  input  logic signed [vsb_pkg::POS_W-1:0]   prev_y,
  input  logic        [vsb_pkg::RAD_W-1:0]   radius,
  input  logic        [vsb_pkg::DAMP_W-1:0]  damping,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vsb_pkg::front_item_t               out_item
);

  logic                          v_r;
  logic                          v_nxt;
  vsb_pkg::front_item_t          item_r;
  vsb_pkg::front_item_t          item_nxt;
  logic signed [vsb_pkg::MV_W-1:0]  mv_x;
  logic signed [vsb_pkg::MV_W-1:0]  mv_y;
  logic signed [vsb_pkg::DMV_W:0]   dmv_x_full;
  logic signed [vsb_pkg::DMV_W:0]   dmv_y_full;
  logic                          load;

  assign in_ready = !v_r || out_ready;
  assign load     = in_valid && in_ready;

  assign mv_x = $signed({pos_x[vsb_pkg::POS_W-1], pos_x})
              - $signed({prev_x[vsb_pkg::POS_W-1], prev_x});
  assign mv_y = $signed({pos_y[vsb_pkg::POS_W-1], pos_y})
              - $signed({prev_y[vsb_pkg::POS_W-1], prev_y});

  // Damping is unsigned, so it enters the product with a zero sign bit.
  assign dmv_x_full = $signed({1'b0, damping}) * mv_x;
  assign dmv_y_full = $signed({1'b0, damping}) * mv_y;

  always_comb begin
    item_nxt.pos_x  = pos_x;
    item_nxt.pos_y  = pos_y;
    item_nxt.mv_x   = mv_x;
    item_nxt.mv_y   = mv_y;
    item_nxt.dmv_x  = dmv_x_full[vsb_pkg::DMV_W-1:0];
    item_nxt.dmv_y  = dmv_y_full[vsb_pkg::DMV_W-1:0];
    item_nxt.radius = radius;
  end

  assign v_nxt = load ? 1'b1 : (out_ready ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

endmodule

// ----- rtl/vsb_queue.sv -----
// Short queue between the front stage and the back pipeline.
module vsb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vsb_pkg::front_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vsb_pkg::front_item_t  out_item
);

  localparam int DEPTH = vsb_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  vsb_pkg::front_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          push;
  logic          pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

  a_fill_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) |-> !in_ready)
    else $error("queue takes a beat while full");

endmodule

// ----- rtl/vsb_back.sv -----
// Back pipeline: force times dt squared, step with saturation, wall clamp and bounce.
module vsb_back #(
  parameter int FRAC_BITS = vsb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vsb_pkg::front_item_t               in_item,
  input  logic        [vsb_pkg::DT_W-1:0]    dt2,
  input  logic signed [vsb_pkg::ACC_W-1:0]   accel_x,
  input  logic signed [vsb_pkg::ACC_W-1:0]   gravity_y,
  input  logic        [vsb_pkg::EXT_W-1:0]   area_width,
  input  logic        [vsb_pkg::EXT_W-1:0]   area_height,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vsb_pkg::POS_W-1:0]   next_x,
  output logic signed [vsb_pkg::POS_W-1:0]   next_y,
  output logic signed [vsb_pkg::POS_W-1:0]   next_prev_x,
  output logic signed [vsb_pkg::POS_W-1:0]   next_prev_y,
  output logic                               hit_x,
  output logic                               hit_y
);

  localparam int POS_W = vsb_pkg::POS_W;
  localparam int MV_W  = vsb_pkg::MV_W;
  localparam int DMV_W = vsb_pkg::DMV_W;
  localparam int ACC_W = vsb_pkg::ACC_W;
  localparam int EXT_W = vsb_pkg::EXT_W;
  localparam int RAD_W = vsb_pkg::RAD_W;
  localparam int DT_W  = vsb_pkg::DT_W;
  // Force width covers both the shifted acceleration and the drag product.
  localparam int FW    = ((ACC_W + FRAC_BITS > DMV_W) ? ACC_W + FRAC_BITS : DMV_W) + 1;
  localparam int PW    = FW + DT_W + 1;
  localparam int TW    = PW - DT_W;
  localparam int SW    = TW + 2;
  localparam int CLW   = ((EXT_W + FRAC_BITS > POS_W) ? EXT_W + FRAC_BITS : POS_W) + 4;

  logic adv1;
  logic adv2;
  logic adv3;

  logic s1_v_r;
  logic s2_v_r;
  logic s3_v_r;

  // Per-axis views of the incoming item and settings.
  logic signed [POS_W-1:0] in_pos [2];
  logic signed [MV_W-1:0]  in_mv  [2];
  logic signed [DMV_W-1:0] in_dmv [2];
  logic signed [ACC_W-1:0] acc    [2];
  logic        [EXT_W-1:0] ext    [2];

  logic signed [FW-1:0]    acc_w  [2];
  logic signed [FW-1:0]    dmv_w  [2];
  logic signed [FW-1:0]    force_w[2];
  logic signed [PW-1:0]    prod   [2];

  logic signed [PW-1:0]    s1_prod_r [2];
  logic signed [POS_W-1:0] s1_pos_r  [2];
  logic signed [MV_W-1:0]  s1_mv_r   [2];
  logic        [RAD_W-1:0] s1_rad_r;

  logic signed [TW-1:0]    term   [2];
  logic signed [SW-1:0]    sum    [2];
  logic signed [POS_W-1:0] n_sat  [2];
  logic signed [CLW-1:0]   hi     [2];

  logic signed [POS_W-1:0] s2_n_r   [2];
  logic signed [POS_W-1:0] s2_pos_r [2];
  logic signed [CLW-1:0]   s2_hi_r  [2];
  logic        [RAD_W-1:0] s2_rad_r;

  logic signed [CLW-1:0]   nw     [2];
  logic signed [CLW-1:0]   radw;
  logic signed [CLW-1:0]   c_lo   [2];
  logic signed [CLW-1:0]   c_fin  [2];
  logic signed [CLW-1:0]   cm     [2];
  logic signed [CLW-1:0]   last_a [2];
  logic signed [CLW-1:0]   last_b [2];
  logic signed [POS_W-1:0] last_s [2];

  logic signed [POS_W-1:0] s3_next_r [2];
  logic signed [POS_W-1:0] s3_prev_r [2];
  logic                    s3_hit_r  [2];

  assign adv3     = !s3_v_r || out_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  assign in_pos[0] = in_item.pos_x;
  assign in_pos[1] = in_item.pos_y;
  assign in_mv[0]  = in_item.mv_x;
  assign in_mv[1]  = in_item.mv_y;
  assign in_dmv[0] = in_item.dmv_x;
  assign in_dmv[1] = in_item.dmv_y;
  assign acc[0]    = accel_x;
  assign acc[1]    = gravity_y;
  assign ext[0]    = area_width;
  assign ext[1]    = area_height;

  assign radw = $signed({{(CLW-RAD_W){1'b0}}, s2_rad_r});

  for (genvar a = 0; a < 2; a++) begin : g_axis
    // Stage 1: force and its product with dt squared.
    assign acc_w[a]   = $signed({{(FW-ACC_W){acc[a][ACC_W-1]}}, acc[a]}) <<< FRAC_BITS;
    assign dmv_w[a]   = $signed({{(FW-DMV_W){in_dmv[a][DMV_W-1]}}, in_dmv[a]});
    assign force_w[a] = acc_w[a] - dmv_w[a];
    assign prod[a]    = force_w[a] * $signed({1'b0, dt2});

    // Stage 2: the slice is a shift that rounds toward minus infinity.
    assign term[a] = $signed(s1_prod_r[a][PW-1:DT_W]);
    assign sum[a]  = $signed({{(SW-POS_W){s1_pos_r[a][POS_W-1]}}, s1_pos_r[a]})
                   + $signed({{(SW-MV_W){s1_mv_r[a][MV_W-1]}}, s1_mv_r[a]})
                   + $signed({{2{term[a][TW-1]}}, term[a]});
    assign n_sat[a] = (sum[a][SW-1:POS_W-1] == '0 || sum[a][SW-1:POS_W-1] == '1)
                    ? sum[a][POS_W-1:0]
                    : (sum[a][SW-1] ? vsb_pkg::POS_MIN_C : vsb_pkg::POS_MAX_C);
    assign hi[a] = $signed({{(CLW-EXT_W){1'b0}}, ext[a]} << FRAC_BITS)
                 - $signed({{(CLW-RAD_W){1'b0}}, s1_rad_r});

    // Stage 3: lower bound first, so an inverted range ends on the upper bound.
    assign nw[a]    = $signed({{(CLW-POS_W){s2_n_r[a][POS_W-1]}}, s2_n_r[a]});
    assign c_lo[a]  = (nw[a] < radw) ? radw : nw[a];
    assign c_fin[a] = (c_lo[a] > s2_hi_r[a]) ? s2_hi_r[a] : c_lo[a];
    assign cm[a]    = c_fin[a] - nw[a];
    assign last_a[a] = $signed({{(CLW-POS_W){s2_pos_r[a][POS_W-1]}}, s2_pos_r[a]}) + cm[a];
    assign last_b[a] = (cm[a] != '0) ? (c_fin[a] <<< 1) - last_a[a] : last_a[a];
    assign last_s[a] = (last_b[a][CLW-1:POS_W-1] == '0 || last_b[a][CLW-1:POS_W-1] == '1)
                     ? last_b[a][POS_W-1:0]
                     : (last_b[a][CLW-1] ? vsb_pkg::POS_MIN_C : vsb_pkg::POS_MAX_C);

    always_ff @(posedge clk) begin
      if (adv1) begin
        s1_prod_r[a] <= prod[a];
        s1_pos_r[a]  <= in_pos[a];
        s1_mv_r[a]   <= in_mv[a];
      end
      if (adv2) begin
        s2_n_r[a]   <= n_sat[a];
        s2_pos_r[a] <= s1_pos_r[a];
        s2_hi_r[a]  <= hi[a];
      end
      if (adv3) begin
        s3_next_r[a] <= c_fin[a][POS_W-1:0];
        s3_prev_r[a] <= last_s[a];
        s3_hit_r[a]  <= (cm[a] != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_rad_r <= in_item.radius;
    end
    if (adv2) begin
      s2_rad_r <= s1_rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= in_valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid   = s3_v_r;
  assign next_x      = s3_next_r[0];
  assign next_y      = s3_next_r[1];
  assign next_prev_x = s3_prev_r[0];
  assign next_prev_y = s3_prev_r[1];
  assign hit_x       = s3_hit_r[0];
  assign hit_y       = s3_hit_r[1];

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !adv2) |=> (s2_v_r && $stable(s2_n_r[0]) && $stable(s2_n_r[1])))
    else $error("stalled stage 2 lost its particle");

  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && s3_v_r && !out_ready) |-> !in_ready)
    else $error("back pipeline takes a beat while full and stalled");

  a_no_hit_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_hit_r[0]) |-> (s3_prev_r[0] == $past(s2_pos_r[0]) || !$past(adv3)))
    else $error("x previous changed without a wall hit");

endmodule

// ----- rtl/verlet_step_with_wall_bounce.sv -----
// Top level: configuration registers, front stage, queue and back pipeline.
//
//   Channel  Dir  Ports                          Content
//   in       in   in_tvalid/in_tready/in_tdata   one particle: position, previous, radius
//   out      out  out_tvalid/out_tready/...      next position, next previous, wall hits
//   cfg      in   cfg_we/cfg_addr/cfg_wdata      six settings registers, write only
//
// One particle enters per clock unless out_tready stalls; each result passes the front
// register, a queue slot and three back stages. The force times dt squared multiplier
// and the clamp adders set the stage boundaries. Reset is synchronous and restores the
// default settings. A stall on out_tready fills the back stages, then the two-entry queue,
// then the front register, before in_tready drops.
module verlet_step_with_wall_bounce #(
  parameter int FRAC_BITS = vsb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pos_x[23:0], pos_y[47:24], prev_x[71:48], prev_y[95:72], radius[111:96]
  input  logic [111:0]                        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // next_x[23:0], next_y[47:24], next_prev_x[71:48], next_prev_y[95:72]
  output logic [95:0]                         out_tdata,
  // hit_x[0], hit_y[1]
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_we,
  input  logic [vsb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [vsb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int POS_W = vsb_pkg::POS_W;

  logic        [vsb_pkg::DT_W-1:0]   step_time_r;
  logic signed [vsb_pkg::ACC_W-1:0]  accel_x_r;
  logic signed [vsb_pkg::ACC_W-1:0]  gravity_y_r;
  logic        [vsb_pkg::DAMP_W-1:0] damping_r;
  logic        [vsb_pkg::EXT_W-1:0]  area_width_r;
  logic        [vsb_pkg::EXT_W-1:0]  area_height_r;
  logic        [vsb_pkg::DT_W-1:0]   dt2_r;
  logic        [2*vsb_pkg::DT_W-1:0] dt_sq;

  logic                  fq_valid;
  logic                  fq_ready;
  vsb_pkg::front_item_t  fq_item;
  logic                  qb_valid;
  logic                  qb_ready;
  vsb_pkg::front_item_t  qb_item;

  logic signed [POS_W-1:0] next_x;
  logic signed [POS_W-1:0] next_y;
  logic signed [POS_W-1:0] next_prev_x;
  logic signed [POS_W-1:0] next_prev_y;
  logic                    hit_x;
  logic                    hit_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r   <= vsb_pkg::STEP_TIME_RST;
      accel_x_r     <= vsb_pkg::ACCEL_X_RST;
      gravity_y_r   <= vsb_pkg::GRAVITY_Y_RST;
      damping_r     <= vsb_pkg::DAMPING_RST;
      area_width_r  <= vsb_pkg::AREA_WIDTH_RST;
      area_height_r <= vsb_pkg::AREA_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (vsb_pkg::cfg_idx_t'(cfg_addr))
        vsb_pkg::CFG_STEP_TIME:   step_time_r   <= cfg_wdata;
        vsb_pkg::CFG_ACCEL_X:     accel_x_r     <= cfg_wdata;
        vsb_pkg::CFG_GRAVITY_Y:   gravity_y_r   <= cfg_wdata;
        vsb_pkg::CFG_DAMPING:     damping_r     <= cfg_wdata[vsb_pkg::DAMP_W-1:0];
        vsb_pkg::CFG_AREA_WIDTH:  area_width_r  <= cfg_wdata[vsb_pkg::EXT_W-1:0];
        vsb_pkg::CFG_AREA_HEIGHT: area_height_r <= cfg_wdata[vsb_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // The squared step is kept in a register so it never chains into the force multiplier.
  assign dt_sq = step_time_r * step_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt2_r <= vsb_pkg::DT2_RST;
    end else begin
      dt2_r <= dt_sq[2*vsb_pkg::DT_W-1:vsb_pkg::DT_W];
    end
  end

  vsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pos_x     (in_tdata[23:0]),
    .pos_y     (in_tdata[47:24]),
    .prev_x    (in_tdata[71:48]),
    .prev_y    (in_tdata[95:72]),
    .radius    (in_tdata[111:96]),
    .damping   (damping_r),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  vsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  vsb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (qb_valid),
    .in_ready    (qb_ready),
    .in_item     (qb_item),
    .dt2         (dt2_r),
    .accel_x     (accel_x_r),
    .gravity_y   (gravity_y_r),
    .area_width  (area_width_r),
    .area_height (area_height_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .next_x      (next_x),
    .next_y      (next_y),
    .next_prev_x (next_prev_x),
    .next_prev_y (next_prev_y),
    .hit_x       (hit_x),
    .hit_y       (hit_y)
  );

  assign out_tdata = {next_prev_y, next_prev_x, next_y, next_x};
  assign out_tuser = {hit_y, hit_x};

  a_dt2_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (dt2_r == 16'((32'($past(step_time_r)) * 32'($past(step_time_r))) >> 16)))
    else $error("squared step out of step with the step register");

  a_queue_feeds_back: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_valid && !fq_ready) |-> qb_valid)
    else $error("queue refuses a beat while empty");

  a_front_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready) |-> (fq_valid && !fq_ready))
    else $error("input stalled without a full queue");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the Verlet step block with wall bounce, one particle per beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vsb_pkg::*;

  localparam int FRAC          = FRAC_BITS_DEF;
  localparam int IDLE_PCT      = 29;
  localparam int NUM_PHASES    = 8;
  localparam int ITEMS_PER_PH  = 140;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int TAIL_CYCLES   = 20;

  // Indexes that decode to no register; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct {
    pos_t             pos_x;
    pos_t             pos_y;
    pos_t             prev_x;
    pos_t             prev_y;
    logic [RAD_W-1:0] radius;
  } particle_t;

  typedef struct {
    pos_t next_x;
    pos_t next_y;
    pos_t next_prev_x;
    pos_t next_prev_y;
    logic hit_x;
    logic hit_y;
  } step_result_t;

  typedef struct {
    logic        [DT_W-1:0]   step_time;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  gravity_y;
    logic        [DAMP_W-1:0] damping;
    logic        [EXT_W-1:0]  area_width;
    logic        [EXT_W-1:0]  area_height;
  } settings_t;

  typedef struct {
    particle_t    stim;
    bit           known;
    step_result_t res;
  } dir_row_t;

  localparam pos_t P_MAX = POS_MAX_C;
  localparam pos_t P_MIN = POS_MIN_C;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  verlet_step_with_wall_bounce u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  settings_t    cur;
  step_result_t pending_q[$];
  int unsigned  errors = 0;
  int unsigned  stalled_cycles = 0;
  bit           quiet = 1'b0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  function automatic longint clip_pos(longint v);
    if (v > longint'(P_MAX)) return longint'(P_MAX);
    if (v < longint'(P_MIN)) return longint'(P_MIN);
    return v;
  endfunction

  // One axis of the Verlet step, then clamp to the walls and bounce the previous point.
  function automatic void advance_axis(input longint p, input longint l, input longint acc,
                                       input longint ext, input longint rad,
                                       input longint dt2, output pos_t np, output pos_t nl,
                                       output logic hit);
    longint mv, drive, term, n, hi, c, cm, last;
    mv    = p - l;
    drive = (acc <<< FRAC) - longint'(cur.damping) * mv;
    term  = (drive * dt2) >>> 16;
    n     = clip_pos(p + mv + term);
    hi    = (ext <<< FRAC) - rad;
    c     = n;
    // Lower bound first so an inverted pair of bounds ends on the upper one.
    if (c < rad) c = rad;
    if (c > hi) c = hi;
    cm   = c - n;
    last = p + cm;
    if (cm != 0) last = 2 * c - last;
    np  = pos_t'(c);
    nl  = pos_t'(clip_pos(last));
    hit = (cm != 0);
  endfunction

  function automatic step_result_t predict_step(particle_t p);
    step_result_t r;
    longint dt2;
    dt2 = (longint'(cur.step_time) * longint'(cur.step_time)) >>> 16;
    advance_axis(p.pos_x, p.prev_x, cur.accel_x, cur.area_width, p.radius, dt2,
                 r.next_x, r.next_prev_x, r.hit_x);
    advance_axis(p.pos_y, p.prev_y, cur.gravity_y, cur.area_height, p.radius, dt2,
                 r.next_y, r.next_prev_y, r.hit_y);
    return r;
  endfunction

  function automatic settings_t rand_settings(bit realistic);
    settings_t s;
    if (realistic) begin
      s.step_time   = 16'($urandom_range(256, 4096));
      s.accel_x     = 16'($urandom_range(0, 2000) - 1000);
      s.gravity_y   = 16'($urandom_range(0, 2000) - 1000);
      s.damping     = 8'($urandom_range(0, 80));
      s.area_width  = 15'($urandom_range(50, 2000));
      s.area_height = 15'($urandom_range(50, 2000));
    end else begin
      s.step_time   = 16'($urandom);
      s.accel_x     = 16'($urandom);
      s.gravity_y   = 16'($urandom);
      s.damping     = 8'($urandom);
      s.area_width  = 15'($urandom);
      s.area_height = 15'($urandom);
    end
    return s;
  endfunction

  // Mostly particles inside the area or close to a wall with small moves, some raw noise.
  function automatic particle_t make_particle(settings_t s);
    particle_t p;
    int unsigned pick;
    int span_x, span_y, px, py, dmax;
    pick   = $urandom_range(0, 99);
    span_x = int'(s.area_width) <<< FRAC;
    span_y = int'(s.area_height) <<< FRAC;
    dmax   = ($urandom_range(0, 9) == 0) ? 65536 : 2048;
    p.radius = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
    if (pick < 20) begin
      p.pos_x  = pos_t'($urandom);
      p.pos_y  = pos_t'($urandom);
      p.prev_x = pos_t'($urandom);
      p.prev_y = pos_t'($urandom);
    end else begin
      if (pick < 65) begin
        px = $urandom_range(0, span_x);
        py = $urandom_range(0, span_y);
      end else begin
        px = ($urandom_range(0, 1) ? span_x : 0) + int'($urandom_range(0, 8191)) - 4096;
        py = ($urandom_range(0, 1) ? span_y : 0) + int'($urandom_range(0, 8191)) - 4096;
      end
      p.pos_x  = pos_t'(px);
      p.pos_y  = pos_t'(py);
      p.prev_x = pos_t'(px - int'($urandom_range(0, 2 * dmax)) + dmax);
      p.prev_y = pos_t'(py - int'($urandom_range(0, 2 * dmax)) + dmax);
    end
    return p;
  endfunction

  task automatic program_settings(input settings_t s, input bit poke_spare);
    cfg_idx_t    regs[6];
    logic [15:0] vals[6];
    regs = '{CFG_STEP_TIME, CFG_ACCEL_X, CFG_GRAVITY_Y, CFG_DAMPING, CFG_AREA_WIDTH,
             CFG_AREA_HEIGHT};
    // Unused upper bits of the narrow registers carry junk that must be dropped.
    vals = '{s.step_time, s.accel_x, s.gravity_y, {8'($urandom), s.damping},
             {1'($urandom), s.area_width}, {1'($urandom), s.area_height}};
    foreach (regs[i]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    if (poke_spare) begin
      cfg_addr  <= CFG_SPARE_A;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
      cfg_addr  <= CFG_SPARE_B;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = s;
  endtask

  task automatic send_particle(input particle_t p, input step_result_t want);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.radius, p.prev_y, p.prev_x, p.pos_y, p.pos_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(want);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic compare_result(input step_result_t want, input step_result_t got);
    logic [23:0] w[6];
    logic [23:0] g[6];
    string       nm[6];
    w  = '{want.next_x, want.next_y, want.next_prev_x, want.next_prev_y,
           24'(want.hit_x), 24'(want.hit_y)};
    g  = '{got.next_x, got.next_y, got.next_prev_x, got.next_prev_y,
           24'(got.hit_x), 24'(got.hit_y)};
    nm = '{"next_x", "next_y", "next_prev_x", "next_prev_y", "hit_x", "hit_y"};
    foreach (w[i]) begin
      if (w[i] !== g[i]) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, nm[i], w[i], g[i]);
        errors++;
      end
    end
  endtask

  // Result side: check every beat, then choose the next ready value.
  always @(posedge clk) begin
    step_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.next_x      = out_tdata[23:0];
      got.next_y      = out_tdata[47:24];
      got.next_prev_x = out_tdata[71:48];
      got.next_prev_y = out_tdata[95:72];
      got.hit_x       = out_tuser[0];
      got.hit_y       = out_tuser[1];
      if (pending_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, got %h/%h",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        compare_result(pending_q.pop_front(), got);
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_row_t  dir_rows[$];
    particle_t p;
    settings_t s;
    cur = '{STEP_TIME_RST, ACCEL_X_RST, GRAVITY_Y_RST, DAMPING_RST, AREA_WIDTH_RST,
            AREA_HEIGHT_RST};

    // Rows checked at the reset settings; known ones carry their result.
    dir_rows.push_back('{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd0}, 1'b1,
                         '{24'sd0, 24'sd14, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{P_MAX, 24'sd0, P_MIN, 24'sd0, 16'd0}, 1'b1,
                         '{24'sd204800, 24'sd14, 24'sd204800, 24'sd0, 1'b1, 1'b0}});
    dir_rows.push_back('{'{24'sd0, 24'sd0, P_MIN, 24'sd0, 16'd0}, 1'b1,
                         '{24'sd204800, 24'sd14, P_MAX, 24'sd0, 1'b1, 1'b0}});
    dir_rows.push_back('{'{P_MIN, 24'sd0, P_MAX, 24'sd0, 16'd0}, 1'b1,
                         '{24'sd0, 24'sd14, 24'sd0, 24'sd0, 1'b1, 1'b0}});
    dir_rows.push_back('{'{24'sd102400, 24'sd25600, 24'sd102400, 24'sd25600, 16'hFFFF}, 1'b1,
                         '{24'sd102400, 24'sd49665, 24'sd102400, 24'sd49679, 1'b0, 1'b1}});
    dir_rows.push_back('{'{P_MAX, P_MAX, P_MAX, P_MAX, 16'hFFFF}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{P_MIN, P_MIN, P_MIN, P_MIN, 16'd0}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 16'hAAAA}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 16'h5555}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'sd100000, 24'sd114944, 24'sd100000, 24'sd112896, 16'd512}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'sd300, 24'sd50000, 24'sd1300, 24'sd50000, 16'd1024}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{-24'sd5000, -24'sd100, -24'sd5000, -24'sd100, 16'd0}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'sd204790, 24'sd60000, 24'sd199800, 24'sd60000, 16'd256}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'sd70000, 24'sd30000, 24'sd70000, 24'sd30000, 16'd57600}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});
    dir_rows.push_back('{'{24'sd70000, 24'sd90000, 24'sd70000, 24'sd90000, 16'd57601}, 1'b0,
                         '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0}});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_particle(dir_rows[i].stim,
                    dir_rows[i].known ? dir_rows[i].res : predict_step(dir_rows[i].stim));
    end
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: s = '{16'hFFFF, 16'sh7FFF, 16'sh7FFF, 8'hFF, 15'h7FFF, 15'h7FFF};
        1: s = '{16'h0000, 16'sh8000, 16'sh8000, 8'h00, 15'h0000, 15'h0000};
        2: s = '{STEP_TIME_RST, ACCEL_X_RST, GRAVITY_Y_RST, DAMPING_RST, AREA_WIDTH_RST,
                 AREA_HEIGHT_RST};
        default: s = rand_settings(ph % 2);
      endcase
      program_settings(s, ph < 2);
      // The defaults phase runs with no idling and opens with a long output hold-off.
      quiet <= (ph == 2);
      if (ph == 2) hold_req <= hold_req + 1;
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        if (ph == 4 && k == ITEMS_PER_PH / 2) drain_results();
        p = make_particle(s);
        send_particle(p, predict_step(p));
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vsb_pkg.sv
rtl/vsb_front.sv
rtl/vsb_queue.sv
rtl/vsb_back.sv
rtl/verlet_step_with_wall_bounce.sv
dv/testbench.sv
